[rtl/core/rcdc_pkg.sv]
// ----------------------------------------------------------------------------
// Rabin chunker package
// Shared types, register indexes, cut causes and the fingerprint ROM builders.
// ----------------------------------------------------------------------------
package rcdc_pkg;

    localparam logic [63:0] RABIN_POLY = 64'hbfe6b8a5bf378d83;
    localparam int          TOP_SHIFT  = 55;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_LEN = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;
    localparam logic [1:0] REG_MASK    = 2'd2;
    localparam logic [1:0] REG_BREAK   = 2'd3;

    // Cut causes
    localparam logic [1:0] CAUSE_CONTENT = 2'd0;
    localparam logic [1:0] CAUSE_MAX_LEN = 2'd1;
    localparam logic [1:0] CAUSE_BUF_END = 2'd2;

    typedef logic [255:0][63:0] t_rom;

    typedef struct packed {
        logic [15:0] min_len;
        logic [15:0] max_len;
        logic [15:0] mask;
        logic [15:0] brk;
    } t_cfg;

    // Carry-less product of a and b, reduced modulo the degree-63 polynomial.
    function automatic logic [63:0] gf_mulmod(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] hi;
        logic [63:0] lo;
        logic        set;
        int          s;
        hi = '0;
        lo = '0;
        for (int i = 0; i < 64; i++) begin
            if (a[i]) begin
                lo = lo ^ (b << i);
                if (i > 0) hi = hi ^ (b >> (64 - i));
            end
        end
        for (int i = 127; i >= 63; i--) begin
            s   = i - 63;
            set = (i >= 64) ? hi[i - 64] : lo[63];
            if (set) begin
                if (s == 0) begin
                    lo = lo ^ RABIN_POLY;
                end else if (s == 64) begin
                    hi = hi ^ RABIN_POLY;
                end else begin
                    lo = lo ^ (RABIN_POLY << s);
                    hi = hi ^ (RABIN_POLY >> (64 - s));
                end
            end
        end
        return lo;
    endfunction

    function automatic t_rom build_red_tab();
        t_rom        tab;
        logic [63:0] x63;
        x63 = RABIN_POLY ^ {1'b1, 63'd0};
        for (int j = 0; j < 256; j++) begin
            tab[j] = gf_mulmod(64'(j), x63) | {64'(j & 1) << 63};
        end
        return tab;
    endfunction

    // Entry i holds i * x^(8*(win_len-1)) mod P, the weight of the oldest byte.
    function automatic t_rom build_out_tab(input int win_len);
        t_rom        red;
        t_rom        tab;
        logic [63:0] span;
        red  = build_red_tab();
        span = 64'd1;
        for (int j = 1; j < win_len; j++) begin
            span = (span << 8) ^ red[span[TOP_SHIFT +: 8]];
        end
        for (int j = 0; j < 256; j++) begin
            tab[j] = gf_mulmod(64'(j), span);
        end
        return tab;
    endfunction

endpackage

[rtl/core/rabin_content_defined_chunker.sv]
// ----------------------------------------------------------------------------
// Rabin content-defined chunker
// Rolling 64-bit Rabin fingerprint over a byte window; closes a chunk on a
// content match, on the maximum length or at the end of a buffer.
//
// Channel  | Dir | Handshake                  | Contents
// s_axis   | in  | tvalid / tready            | tdata: data byte; tlast: buffer end
// m_axis   | out | tvalid / tready            | tdata: length, fingerprint; tuser: cause
// cfg      | in  | we (no wait)               | addr: register index; wdata: value
//
// One byte per cycle while no result waits unaccepted: a byte is held in the
// input register, then the two ROM lookups and the cut test run combinationally
// into the result register, from which the chunk result is offered on m_axis.
// Reset is synchronous; it clears the window, fingerprint and length counter
// and loads the default register values. While a result waits unaccepted no
// byte leaves the input register, so the input stalls with it; with the
// output ready, bytes flow back to back.
// ----------------------------------------------------------------------------
module rabin_content_defined_chunker #(
    parameter int WINDOW_LEN = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // buffer_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [15:0] chunk_length, [79:16] fingerprint_out
    output logic [1:0]  o_m_axis_tuser,   // [1:0] cut_cause
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import rcdc_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        w_advance;
    logic        w_out_valid;
    logic [63:0] w_print_next;
    logic [15:0] w_length;
    logic [1:0]  w_cause;
    logic [63:0] w_print;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len <= 16'd2048;
            r_cfg.max_len <= 16'd65535;
            r_cfg.mask    <= 16'd8191;
            r_cfg.brk     <= 16'd120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_LEN: r_cfg.min_len <= i_cfg_wdata;
                REG_MAX_LEN: r_cfg.max_len <= i_cfg_wdata;
                REG_MASK:    r_cfg.mask    <= i_cfg_wdata;
                REG_BREAK:   r_cfg.brk     <= i_cfg_wdata;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // A byte moves on whenever the result register is free or being emptied.
    assign w_advance       = r_in_valid && (!w_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    rcdc_fingerprint #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_fingerprint (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_byte       (r_in_byte),
        .o_print_next (w_print_next)
    );

    rcdc_cut_logic u_cut_logic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_last       (r_in_last),
        .i_print_next (w_print_next),
        .i_cfg        (r_cfg),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (w_out_valid),
        .o_length     (w_length),
        .o_cause      (w_cause),
        .o_print      (w_print)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = {w_print, w_length};
    assign o_m_axis_tuser  = w_cause;

endmodule

[rtl/core/rcdc_fingerprint.sv]
// ----------------------------------------------------------------------------
// Rabin chunker rolling fingerprint
// Byte window as a shift line, fingerprint register and the two ROM lookups.
// ----------------------------------------------------------------------------
module rcdc_fingerprint #(
    parameter int WINDOW_LEN = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_print_next
);
    import rcdc_pkg::*;

    localparam t_rom RED_TAB = build_red_tab();
    localparam t_rom OUT_TAB = build_out_tab(WINDOW_LEN);

    logic [WINDOW_LEN-1:0][7:0] r_win;
    logic [63:0]                r_print;
    logic [63:0]                n_print;
    logic [63:0]                w_removed;

    // The oldest byte sits at the far end of the shift line.
    assign w_removed    = r_print ^ OUT_TAB[r_win[WINDOW_LEN-1]];
    assign n_print      = {w_removed[55:0], i_byte} ^ RED_TAB[w_removed[TOP_SHIFT +: 8]];
    assign o_print_next = n_print;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_print <= '0;
        end else if (i_en) begin
            r_win   <= {r_win[WINDOW_LEN-2:0], i_byte};
            r_print <= n_print;
        end
    end

endmodule

[rtl/core/rcdc_cut_logic.sv]
// ----------------------------------------------------------------------------
// Rabin chunker cut decision
// Chunk length counter, boundary test and the result register.
// ----------------------------------------------------------------------------
module rcdc_cut_logic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_last,
    input  logic [63:0]        i_print_next,
    input  rcdc_pkg::t_cfg     i_cfg,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_length,
    output logic [1:0]         o_cause,
    output logic [63:0]        o_print
);
    import rcdc_pkg::*;

    logic [15:0] r_len;
    logic [15:0] n_len;
    logic        r_out_valid;
    logic [15:0] r_length;
    logic [1:0]  r_cause;
    logic [63:0] r_print;
    logic        w_content;
    logic        w_max_hit;
    logic        w_cut;
    logic [1:0]  w_cause;

    assign n_len     = r_len + 16'd1;
    assign w_content = ((i_print_next[15:0] & i_cfg.mask) == i_cfg.brk)
                       && (n_len >= i_cfg.min_len);
    assign w_max_hit = n_len >= i_cfg.max_len;
    assign w_cut     = w_content || w_max_hit || i_last;

    // The lowest cause code wins when several hold together.
    always_comb begin
        if (w_content) begin
            w_cause = CAUSE_CONTENT;
        end else if (w_max_hit) begin
            w_cause = CAUSE_MAX_LEN;
        end else begin
            w_cause = CAUSE_BUF_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_len <= w_cut ? 16'd0 : n_len;
            end
            if (i_en && w_cut) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_cut) begin
            r_length <= n_len;
            r_cause  <= w_cause;
            r_print  <= i_print_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_length    = r_length;
    assign o_cause     = r_cause;
    assign o_print     = r_print;

endmodule
